// File: rtl/ppi_pkg.sv
// Package for the particle pool integrator: slot record, FSM states,
// stream field offsets, register indexes and reset values.
// No dependencies.
package ppi_pkg;

	localparam int POOL_SIZE_DEF = 256;

	// configuration port
	localparam int CFG_W     = 24;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_GRAV_NORMAL  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRAV_SMOKE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SMOKE_GROWTH = 2'd2;
	localparam logic [CFG_W-1:0] GRAV_NORMAL_RST  = 24'd327680;
	localparam logic [CFG_W-1:0] GRAV_SMOKE_RST   = 24'd65536;
	localparam logic [CFG_W-1:0] SMOKE_GROWTH_RST = 24'd3277;

	// item codes
	localparam logic      OP_TICK    = 1'b1;
	localparam logic [1:0] KIND_SMOKE = 2'd2;

	// field widths
	localparam int VAL_W     = 32;
	localparam int LIFE_IN_W = 24;
	localparam int SIZE_IN_W = 24;
	localparam int KIND_W    = 2;
	localparam int DT_W      = 16;
	localparam int LIFE_W    = 25;   // lifetime in the slot, may go negative
	localparam int COUNT_W   = 9;
	localparam int COUNT_MAX = 511;

	// input tdata layout, lowest bit first
	localparam int POS_X_LSB = 0;
	localparam int POS_Y_LSB = 32;
	localparam int POS_Z_LSB = 64;
	localparam int VEL_X_LSB = 96;
	localparam int VEL_Y_LSB = 128;
	localparam int VEL_Z_LSB = 160;
	localparam int LIFE_LSB  = 192;
	localparam int SIZE_LSB  = 216;
	localparam int KIND_LSB  = 240;
	localparam int DT_LSB    = 242;
	localparam int IN_TDATA_W  = 264;
	localparam int OUT_TDATA_W = 16;

	typedef struct packed {
		logic signed [VAL_W-1:0]  pos_x;
		logic signed [VAL_W-1:0]  pos_y;
		logic signed [VAL_W-1:0]  pos_z;
		logic signed [VAL_W-1:0]  vel_x;
		logic signed [VAL_W-1:0]  vel_y;
		logic signed [VAL_W-1:0]  vel_z;
		logic signed [LIFE_W-1:0] life;
		logic [VAL_W-1:0]         size;
		logic [KIND_W-1:0]        kind;
	} slot_t;

	// status of the write-back stage toward the controller
	typedef struct packed {
		logic valid;
		logic live;
	} upd_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_TICK_RD,
		ST_TICK_DRAIN,
		ST_DONE
	} state_t;

	// clamp a 33-bit two's complement sum to the signed 32-bit range
	function automatic logic [VAL_W-1:0] sat_s32(input logic [VAL_W:0] v);
		logic [VAL_W-1:0] r;
		if (v[VAL_W] != v[VAL_W-1])
			r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/ppi_slot_mem.sv
// Slot memory of the particle pool: one wide word per slot,
// one write and one registered read per cycle. Uses ppi_pkg.
module ppi_slot_mem
	import ppi_pkg::*;
#(
	parameter int DEPTH = POOL_SIZE_DEF,
	parameter int AW    = $clog2(POOL_SIZE_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);

	slot_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/ppi_update.sv
// Euler update datapath: multiply stage on the read slot, then
// add/saturate stage that produces the write-back word. Uses ppi_pkg.
module ppi_update
	import ppi_pkg::*;
#(
	parameter int AW = $clog2(POOL_SIZE_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_fresh,   // slot was written since reset
	input  logic [AW-1:0]      in_addr,
	input  slot_t              rd_data,
	input  logic [DT_W-1:0]    dt,
	input  logic [CFG_W-1:0]   gn_dt,
	input  logic [CFG_W-1:0]   gs_dt,
	input  logic [CFG_W-1:0]   grow_dt,
	output upd_stat_t          stat,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output slot_t              wr_data
);

	localparam int PROD_W = VAL_W + DT_W + 1;

	logic                    live_in;
	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
	logic signed [DT_W:0]     dt_s;

	logic                valid_s2, live_s2;
	logic [AW-1:0]       addr_s2;
	slot_t               rec_s2;
	logic [VAL_W-1:0]    vdt_x_s2, vdt_y_s2, vdt_z_s2;

	logic                smoke;
	logic [CFG_W-1:0]    gdt;
	logic [VAL_W:0]      sum_x, sum_y, sum_z, sum_vy, sum_sz;
	logic [LIFE_W-1:0]   new_life;
	slot_t               upd;

	assign live_in = in_fresh && !rd_data.life[LIFE_W-1] && (rd_data.life != '0);
	assign dt_s    = $signed({1'b0, dt});
	assign prod_x  = $signed(rd_data.vel_x) * dt_s;
	assign prod_y  = $signed(rd_data.vel_y) * dt_s;
	assign prod_z  = $signed(rd_data.vel_z) * dt_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			live_s2  <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			live_s2  <= in_valid && live_in;
		end
	end

	// arithmetic shift right by 16 is the floor of the scaled product
	always_ff @(posedge clk) begin
		addr_s2  <= in_addr;
		rec_s2   <= rd_data;
		vdt_x_s2 <= prod_x[VAL_W+DT_W-1:DT_W];
		vdt_y_s2 <= prod_y[VAL_W+DT_W-1:DT_W];
		vdt_z_s2 <= prod_z[VAL_W+DT_W-1:DT_W];
	end

	always_comb begin
		smoke    = (rec_s2.kind == KIND_SMOKE);
		gdt      = smoke ? gs_dt : gn_dt;
		sum_x    = {rec_s2.pos_x[VAL_W-1], rec_s2.pos_x} + {vdt_x_s2[VAL_W-1], vdt_x_s2};
		sum_y    = {rec_s2.pos_y[VAL_W-1], rec_s2.pos_y} + {vdt_y_s2[VAL_W-1], vdt_y_s2};
		sum_z    = {rec_s2.pos_z[VAL_W-1], rec_s2.pos_z} + {vdt_z_s2[VAL_W-1], vdt_z_s2};
		sum_vy   = {rec_s2.vel_y[VAL_W-1], rec_s2.vel_y}
			- {{(VAL_W+1-CFG_W){1'b0}}, gdt};
		sum_sz   = {1'b0, rec_s2.size} + {{(VAL_W+1-CFG_W){1'b0}}, grow_dt};
		new_life = rec_s2.life - {{(LIFE_W-DT_W){1'b0}}, dt};

		upd       = rec_s2;
		upd.pos_x = sat_s32(sum_x);
		upd.pos_y = sat_s32(sum_y);
		upd.pos_z = sat_s32(sum_z);
		upd.vel_y = sat_s32(sum_vy);
		upd.life  = new_life;
		if (smoke)
			upd.size = sum_sz[VAL_W] ? '1 : sum_sz[VAL_W-1:0];
	end

	assign wr_en      = valid_s2 && live_s2;
	assign wr_addr    = addr_s2;
	assign wr_data    = upd;
	assign stat.valid = valid_s2;
	assign stat.live  = live_s2 && !new_life[LIFE_W-1] && (new_life != '0);

endmodule

// File: rtl/particle_pool_integrator.sv
// Particle pool integrator: ring pool of particles, emit and Euler tick.
// Emit: read the slot being replaced, then write it and update the live count.
// Tick: a walk over the slot memory at one slot per cycle through its single read port.
// One item in work at a time; the next item is taken while a result waits.
// Async reset clears control, counts and registers; slot memory is not cleared,
// a fill count marks slots never emitted into as dead, so no clearing pass.
module particle_pool_integrator
	import ppi_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life, size_in, kind, dt, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,   // op
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // active_count, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int AW = $clog2(POOL_SIZE);
	localparam int CW = $clog2(POOL_SIZE + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0] grav_n_q, grav_s_q, growth_q;
	logic [DT_W-1:0]  dt_q;
	logic [CFG_W-1:0] gn_dt_q, gs_dt_q, grow_dt_q;
	slot_t            emit_rec_q;
	logic [AW-1:0]    write_slot_q, addr_q;
	logic [CW-1:0]    fill_q, live_total_q, cnt_acc_q;
	logic             m_tvalid_q;
	logic [COUNT_W-1:0] m_cnt_q;

	logic             s1_valid_s1, s1_fresh_s1;
	logic [AW-1:0]    s1_addr_s1;

	logic             accept, walk_issue, emit_wr, load_out;
	logic             mem_re, mem_we;
	logic [AW-1:0]    mem_raddr, mem_waddr;
	slot_t            mem_wdata, rd_data, emit_rec;
	upd_stat_t        upd_stat;
	logic             upd_we;
	logic [AW-1:0]    upd_waddr;
	slot_t            upd_wdata;

	logic [DT_W-1:0]     in_dt;
	logic [CFG_W+DT_W-1:0] gn_prod, gs_prod, grow_prod;
	logic                old_live, new_live;
	logic [CW-1:0]       emit_cnt;
	logic [31:0]         lt32;
	logic [COUNT_W-1:0]  active_cnt;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign in_dt     = s_tdata[DT_LSB +: DT_W];
	assign gn_prod   = grav_n_q * in_dt;
	assign gs_prod   = grav_s_q * in_dt;
	assign grow_prod = growth_q * in_dt;

	always_comb begin
		emit_rec       = '0;
		emit_rec.pos_x = s_tdata[POS_X_LSB +: VAL_W];
		emit_rec.pos_y = s_tdata[POS_Y_LSB +: VAL_W];
		emit_rec.pos_z = s_tdata[POS_Z_LSB +: VAL_W];
		emit_rec.vel_x = s_tdata[VEL_X_LSB +: VAL_W];
		emit_rec.vel_y = s_tdata[VEL_Y_LSB +: VAL_W];
		emit_rec.vel_z = s_tdata[VEL_Z_LSB +: VAL_W];
		emit_rec.life  = {{(LIFE_W-LIFE_IN_W){1'b0}}, s_tdata[LIFE_LSB +: LIFE_IN_W]};
		emit_rec.size  = {{(VAL_W-SIZE_IN_W){1'b0}}, s_tdata[SIZE_LSB +: SIZE_IN_W]};
		emit_rec.kind  = s_tdata[KIND_LSB +: KIND_W];
	end

	// controller
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = addr_q;
		walk_issue = 1'b0;
		emit_wr    = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = (s_tuser == OP_TICK) ? ST_TICK_RD : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = write_slot_q;
				state_d   = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				emit_wr = 1'b1;
				state_d = ST_DONE;
			end
			ST_TICK_RD: begin
				mem_re     = 1'b1;
				walk_issue = 1'b1;
				if (addr_q == AW'(POOL_SIZE - 1))
					state_d = ST_TICK_DRAIN;
			end
			ST_TICK_DRAIN: begin
				if (!s1_valid_s1 && !upd_stat.valid)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// emit replaces a slot: count loses the old particle if it was alive
	assign old_live = (CW'(write_slot_q) < fill_q) && !rd_data.life[LIFE_W-1]
		&& (rd_data.life != '0);
	assign new_live = (emit_rec_q.life != '0);
	assign emit_cnt = live_total_q - CW'(old_live) + CW'(new_live);

	assign lt32       = 32'(live_total_q);
	assign active_cnt = (lt32 > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : lt32[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			grav_n_q     <= GRAV_NORMAL_RST;
			grav_s_q     <= GRAV_SMOKE_RST;
			growth_q     <= SMOKE_GROWTH_RST;
			write_slot_q <= '0;
			fill_q       <= '0;
			live_total_q <= '0;
			cnt_acc_q    <= '0;
			addr_q       <= '0;
			s1_valid_s1  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			s1_valid_s1 <= walk_issue;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GRAV_NORMAL:  grav_n_q <= cfg_data;
					REG_GRAV_SMOKE:   grav_s_q <= cfg_data;
					REG_SMOKE_GROWTH: growth_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				addr_q    <= '0;
				cnt_acc_q <= '0;
			end else begin
				if (walk_issue)
					addr_q <= addr_q + AW'(1);
				if (upd_stat.valid && upd_stat.live)
					cnt_acc_q <= cnt_acc_q + CW'(1);
			end

			if (emit_wr) begin
				live_total_q <= emit_cnt;
				write_slot_q <= (write_slot_q == AW'(POOL_SIZE - 1)) ? '0
					: write_slot_q + AW'(1);
				if (fill_q != CW'(POOL_SIZE))
					fill_q <= fill_q + CW'(1);
			end else if (state_q == ST_TICK_DRAIN && state_d == ST_DONE) begin
				live_total_q <= cnt_acc_q;
			end

			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q       <= in_dt;
			gn_dt_q    <= gn_prod[CFG_W+DT_W-1:DT_W];
			gs_dt_q    <= gs_prod[CFG_W+DT_W-1:DT_W];
			grow_dt_q  <= grow_prod[CFG_W+DT_W-1:DT_W];
			emit_rec_q <= emit_rec;
		end
		s1_fresh_s1 <= (CW'(addr_q) < fill_q);
		s1_addr_s1  <= addr_q;
		if (load_out)
			m_cnt_q <= active_cnt;
	end

	assign mem_we    = emit_wr || upd_we;
	assign mem_waddr = emit_wr ? write_slot_q : upd_waddr;
	assign mem_wdata = emit_wr ? emit_rec_q : upd_wdata;

	ppi_slot_mem #(
		.DEPTH (POOL_SIZE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	ppi_update #(
		.AW (AW)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_valid_s1),
		.in_fresh (s1_fresh_s1),
		.in_addr  (s1_addr_s1),
		.rd_data  (rd_data),
		.dt       (dt_q),
		.gn_dt    (gn_dt_q),
		.gs_dt    (gs_dt_q),
		.grow_dt  (grow_dt_q),
		.stat     (upd_stat),
		.wr_en    (upd_we),
		.wr_addr  (upd_waddr),
		.wr_data  (upd_wdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, m_cnt_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_total_q <= CW'(POOL_SIZE) && cnt_acc_q <= CW'(POOL_SIZE))
		else $error("live count exceeds pool size");

	a_fill_tracks_ring: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != CW'(POOL_SIZE) |-> CW'(write_slot_q) == fill_q)
		else $error("fill count out of step with ring pointer");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_EMIT_WR || state_q == ST_TICK_RD
			|| state_q == ST_TICK_DRAIN))
		else $error("slot memory written outside emit or tick");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_wr && upd_we))
		else $error("emit and tick write-back collide");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!m_tvalid_q || m_tready) |=> m_tvalid_q
			&& state_q == ST_IDLE)
		else $error("result not presented on completion");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for particle_pool_integrator: random emit/tick requests,
// a pool model that predicts the live count, four pacing phases, register sets.
// Depends on ppi_pkg and the particle_pool_integrator RTL.

import ppi_pkg::*;

typedef struct {
	logic                    op;
	logic signed [VAL_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic [LIFE_IN_W-1:0]    life;
	logic [SIZE_IN_W-1:0]    size_in;
	logic [KIND_W-1:0]       kind;
	logic [DT_W-1:0]         dt;
} particle_req_t;

localparam logic OP_EMIT = 1'b0;

// Pool model: own copy of the slots and registers, queue of expected live counts.
class pool_board;
	logic signed [VAL_W-1:0] px [POOL_SIZE_DEF];
	logic signed [VAL_W-1:0] py [POOL_SIZE_DEF];
	logic signed [VAL_W-1:0] pz [POOL_SIZE_DEF];
	logic signed [VAL_W-1:0] vx [POOL_SIZE_DEF];
	logic signed [VAL_W-1:0] vy [POOL_SIZE_DEF];
	logic signed [VAL_W-1:0] vz [POOL_SIZE_DEF];
	logic [VAL_W-1:0]        size_of [POOL_SIZE_DEF];
	logic [KIND_W-1:0]       kind_of [POOL_SIZE_DEF];
	int                      life_of [POOL_SIZE_DEF];
	int unsigned             next_slot;
	logic [CFG_W-1:0]        grav_normal, grav_smoke, growth;
	logic [COUNT_W-1:0]      live_q [$];
	int                      errors, n_emit, n_tick, n_result, peak;

	function void clear();
		for (int i = 0; i < POOL_SIZE_DEF; i++) begin
			px[i] = '0; py[i] = '0; pz[i] = '0;
			vx[i] = '0; vy[i] = '0; vz[i] = '0;
			size_of[i] = '0; kind_of[i] = '0; life_of[i] = 0;
		end
		next_slot = 0;
		grav_normal = GRAV_NORMAL_RST;
		grav_smoke = GRAV_SMOKE_RST;
		growth = SMOKE_GROWTH_RST;
		live_q.delete();
		errors = 0; n_emit = 0; n_tick = 0; n_result = 0; peak = 0;
	endfunction

	function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_GRAV_NORMAL:  grav_normal = val;
			REG_GRAV_SMOKE:   grav_smoke = val;
			REG_SMOKE_GROWTH: growth = val;
			default: ;
		endcase
	endfunction

	// exact product, then floor of the Q16.16 rescale
	function longint scale(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	function logic signed [VAL_W-1:0] clamp32(longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < -longint'(32'sh7FFF_FFFF) - 1)
			return 32'sh8000_0000;
		return v[VAL_W-1:0];
	endfunction

	function int pending();
		return live_q.size();
	endfunction

	function void note_item(particle_req_t r);
		longint           step, g, grown;
		bit               smoke;
		int               n;
		if (r.op == OP_EMIT) begin
			px[next_slot] = r.pos_x; py[next_slot] = r.pos_y; pz[next_slot] = r.pos_z;
			vx[next_slot] = r.vel_x; vy[next_slot] = r.vel_y; vz[next_slot] = r.vel_z;
			life_of[next_slot] = int'({8'b0, r.life});
			size_of[next_slot] = {8'b0, r.size_in};
			kind_of[next_slot] = r.kind;
			next_slot = (next_slot + 1) % POOL_SIZE_DEF;
			n_emit++;
		end else begin
			step = longint'(r.dt);
			for (int i = 0; i < POOL_SIZE_DEF; i++) begin
				if (life_of[i] <= 0)
					continue;
				smoke = (kind_of[i] == KIND_SMOKE);
				life_of[i] = life_of[i] - int'(step);
				// position moves with the old velocity
				px[i] = clamp32(longint'(px[i]) + scale(longint'(vx[i]), step));
				py[i] = clamp32(longint'(py[i]) + scale(longint'(vy[i]), step));
				pz[i] = clamp32(longint'(pz[i]) + scale(longint'(vz[i]), step));
				g = smoke ? longint'(grav_smoke) : longint'(grav_normal);
				vy[i] = clamp32(longint'(vy[i]) - scale(g, step));
				if (smoke) begin
					grown = longint'(size_of[i]) + scale(longint'(growth), step);
					size_of[i] = (grown > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
						: grown[VAL_W-1:0];
				end
			end
			n_tick++;
		end
		n = 0;
		for (int i = 0; i < POOL_SIZE_DEF; i++)
			if (life_of[i] > 0)
				n++;
		if (n > COUNT_MAX)
			n = COUNT_MAX;
		if (n > peak)
			peak = n;
		live_q.push_back(n[COUNT_W-1:0]);
	endfunction

	task report(string msg);
		if (errors < 40)
			$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic [COUNT_W-1:0] got);
		logic [COUNT_W-1:0] want;
		n_result++;
		if (live_q.size() == 0) begin
			report($sformatf("result %0d with count %0d but no request pending",
				n_result, got));
		end else begin
			want = live_q.pop_front();
			if (got !== want)
				report($sformatf("result %0d: active_count %0d, expected %0d",
					n_result, got, want));
		end
	endtask
endclass

module tb;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [KIND_W-1:0] KIND_FLASH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPARK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BLAST = 2'd3;
	localparam logic signed [VAL_W-1:0] SMAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] SMIN = 32'sh8000_0000;
	localparam logic [LIFE_IN_W-1:0] LIFE_MAX = 24'hFF_FFFF;
	localparam logic [SIZE_IN_W-1:0] SIZE_MAX = 24'hFF_FFFF;
	localparam logic [DT_W-1:0] DT_MAX = 16'hFFFF;
	localparam int ITEMS_PER_PHASE = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	int        idle_pct;
	int        stall_pct;
	pool_board sb;

	particle_pool_integrator #(.POOL_SIZE(POOL_SIZE_DEF)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [IN_TDATA_W-1:0] pack_req(particle_req_t r);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[POS_X_LSB +: VAL_W]     = r.pos_x;
		d[POS_Y_LSB +: VAL_W]     = r.pos_y;
		d[POS_Z_LSB +: VAL_W]     = r.pos_z;
		d[VEL_X_LSB +: VAL_W]     = r.vel_x;
		d[VEL_Y_LSB +: VAL_W]     = r.vel_y;
		d[VEL_Z_LSB +: VAL_W]     = r.vel_z;
		d[LIFE_LSB  +: LIFE_IN_W] = r.life;
		d[SIZE_LSB  +: SIZE_IN_W] = r.size_in;
		d[KIND_LSB  +: KIND_W]    = r.kind;
		d[DT_LSB    +: DT_W]      = r.dt;
		return d;
	endfunction

	function automatic particle_req_t unpack_req(logic [IN_TDATA_W-1:0] d, logic op);
		particle_req_t r;
		r.op      = op;
		r.pos_x   = d[POS_X_LSB +: VAL_W];
		r.pos_y   = d[POS_Y_LSB +: VAL_W];
		r.pos_z   = d[POS_Z_LSB +: VAL_W];
		r.vel_x   = d[VEL_X_LSB +: VAL_W];
		r.vel_y   = d[VEL_Y_LSB +: VAL_W];
		r.vel_z   = d[VEL_Z_LSB +: VAL_W];
		r.life    = d[LIFE_LSB  +: LIFE_IN_W];
		r.size_in = d[SIZE_LSB  +: SIZE_IN_W];
		r.kind    = d[KIND_LSB  +: KIND_W];
		r.dt      = d[DT_LSB    +: DT_W];
		return r;
	endfunction

	// fully random request, every field over its whole range
	function automatic particle_req_t rand_noise();
		particle_req_t r;
		r.op      = $urandom_range(0, 1);
		r.pos_x   = $urandom();
		r.pos_y   = $urandom();
		r.pos_z   = $urandom();
		r.vel_x   = $urandom();
		r.vel_y   = $urandom();
		r.vel_z   = $urandom();
		r.life    = $urandom();
		r.size_in = $urandom();
		r.kind    = $urandom_range(0, 3);
		r.dt      = $urandom();
		return r;
	endfunction

	// lifetimes mostly short so slots die within a few ticks
	function automatic particle_req_t rand_emit();
		particle_req_t r;
		int unsigned   sel;
		r = rand_noise();
		r.op = OP_EMIT;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			r.life = '0;
		else if (sel < 15)
			r.life = LIFE_MAX;
		else if (sel >= 30)
			r.life = $urandom_range(1, 150000);
		return r;
	endfunction

	function automatic particle_req_t rand_tick();
		particle_req_t r;
		int unsigned   sel;
		r = rand_noise();
		r.op = OP_TICK;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			r.dt = '0;
		else if (sel < 16)
			r.dt = DT_MAX;
		else
			r.dt = $urandom_range(1, 40000);
		return r;
	endfunction

	always @(posedge clk)
		m_tready <= (int'($urandom_range(0, 99)) >= stall_pct);

	// request and result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(unpack_req(s_tdata, s_tuser));
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[COUNT_W-1:0]);
		end
	end

	task automatic send_req(input particle_req_t r);
		while (int'($urandom_range(0, 99)) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= pack_req(r);
		s_tuser  <= r.op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] gn, input logic [CFG_W-1:0] gs,
			input logic [CFG_W-1:0] gr);
		write_reg(REG_GRAV_NORMAL, gn);
		write_reg(REG_GRAV_SMOKE, gs);
		write_reg(REG_SMOKE_GROWTH, gr);
		write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_req('{OP_EMIT, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, LIFE_MAX, SIZE_MAX,
			KIND_FLASH, 16'h0000});
		send_req('{OP_EMIT, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 24'd1, 24'd0,
			KIND_SPARK, DT_MAX});
		// zero life: written but dead at once
		send_req('{OP_EMIT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd100,
			KIND_SMOKE, 16'h1234});
		send_req('{OP_EMIT, 32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 32'sd65536,
			-32'sd65536, 24'd65536, SIZE_MAX, KIND_SMOKE, 16'h0000});
		send_req('{OP_EMIT, 32'sd1, 32'sd2, 32'sd3, -32'sd4, 32'sd5, -32'sd6, 24'd40000,
			24'd65536, KIND_BLAST, 16'h0000});
		// zero step only reports the count
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, 16'h0000});
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, 16'h0001});
		// lifetimes driven below zero
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, DT_MAX});
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, DT_MAX});
		send_req('{OP_EMIT, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, LIFE_MAX, SIZE_MAX,
			KIND_SMOKE, 16'h0000});
		send_req('{OP_EMIT, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, LIFE_MAX, 24'd0,
			KIND_FLASH, 16'h0000});
		// tick with junk in the fields it ignores
		send_req('{OP_TICK, 32'shA5A5_A5A5, 32'sh5A5A_5A5A, SMAX, SMIN, 32'sh0F0F_0F0F,
			32'shF0F0_F0F0, LIFE_MAX, SIZE_MAX, KIND_BLAST, DT_MAX});
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, DT_MAX});
		send_req('{OP_EMIT, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 24'd1, 24'd7,
			KIND_SMOKE, 16'h0000});
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, 16'h0000});
		send_req('{OP_TICK, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 24'd0,
			KIND_FLASH, 16'h8000});
	endtask

	// more emits than slots, all long lived: full pool, then live slots overwritten
	task automatic fill_pool();
		particle_req_t r;
		repeat (POOL_SIZE_DEF + 24) begin
			r = rand_emit();
			r.life = $urandom_range(24'h80_0000, LIFE_MAX);
			send_req(r);
		end
		send_req(rand_tick());
		send_req(rand_tick());
	endtask

	task automatic run_random(input int n);
		int          sent;
		int unsigned sel;
		int unsigned n_emits;
		int unsigned n_ticks;
		sent = 0;
		while (sent < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				hold_until_drained();
			if (sel < 80) begin
				n_emits = $urandom_range(1, 12);
				n_ticks = $urandom_range(1, 3);
				repeat (n_emits)
					send_req(rand_emit());
				repeat (n_ticks)
					send_req(rand_tick());
				sent += n_emits + n_ticks;
			end else begin
				send_req(rand_noise());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		sb = new;
		sb.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			// registers change only with the pool idle
			case (ph)
				0: ;
				1: begin hold_until_drained(); load_regs('0, '0, '0); end
				2: begin hold_until_drained(); load_regs('1, '1, '1); end
				default: begin
					hold_until_drained();
					load_regs($urandom_range(0, 24'h0F_FFFF), $urandom_range(0, 24'h0F_FFFF),
						$urandom());
				end
			endcase
			if (ph == 0)
				run_directed();
			if (ph == 1)
				fill_pool();
			run_random(ITEMS_PER_PHASE);
		end

		hold_until_drained();
		repeat (POOL_SIZE_DEF + 8) @(posedge clk);
		$display("Run: %0d emit and %0d tick requests, %0d results checked, peak live %0d.",
			sb.n_emit, sb.n_tick, sb.n_result, sb.peak);
		$display("Four pacing phases, reset/zero/full/random registers; %0d mismatches.",
			sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("Verification failed");
		$finish;
	end

endmodule
